/* rtl/sbps_pkg.sv */
`default_nettype none
package sbps_pkg;

	localparam int MAX_BODIES_DEF = 16;

	localparam int GRAV_Q          = -642908;
	localparam int REST_Q          = 29491;
	localparam int FRIC_Q          = 60293;
	localparam int ONE_PLUS_REST_Q = 95027;
	localparam int DT_LIMIT        = 2184;

	// divider: dividend up to |d|<<16, divisor up to ra+rb or inva+invb
	localparam int DVD_W = 49;
	localparam int DSR_W = 33;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_STEP  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [30:0]        body_radius;
		logic signed [31:0] body_mass;
		logic [15:0]        time_step;
		logic [3:0]         body_index;
	} cmd_t;

	typedef struct packed {
		logic [3:0]         out_handle;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               error;
	} res_t;

	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [2:0][31:0] vel;
		logic [30:0]      rad;
		logic [31:0]      inv;
		logic             stat;
	} body_t;

	function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
		logic signed [71:0] smax;
		logic signed [71:0] smin;
		smax = 72'sd2147483647;
		smin = -72'sd2147483648;
		if (v > smax) begin
			return 32'sh7FFF_FFFF;
		end else if (v < smin) begin
			return 32'sh8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage
`default_nettype wire

/* rtl/sbps_div.sv */
`default_nettype none
module sbps_div import sbps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q <= dividend;
				rem_q <= '0;
				dsr_q <= divisor;
				cnt_q <= CNT_W'(DVD_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], fits};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

/* rtl/sbps_sqrt.sv */
`default_nettype none
module sbps_sqrt import sbps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] x_q;
	logic [31:0] root_q;
	logic [33:0] rem_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [35:0] trial;
	logic [35:0] cmp;
	logic [35:0] diff;
	logic        fits;

	assign trial = {rem_q, x_q[63:62]};
	assign cmp   = {2'b00, root_q, 2'b01};
	assign diff  = trial - cmp;
	assign fits  = trial >= cmp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			root_q <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q    <= radicand;
				root_q <= '0;
				rem_q  <= '0;
				cnt_q  <= 6'd32;
				run_q  <= 1'b1;
			end else if (run_q) begin
				rem_q  <= fits ? diff[33:0] : trial[33:0];
				root_q <= {root_q[30:0], fits};
				x_q    <= {x_q[61:0], 2'b00};
				cnt_q  <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

/* rtl/sphere_body_physics_step.sv */
// Sphere body table with gravity, floor bounce and pairwise impulse collisions.
// Command channel: an item (cmd) is taken when start is high and busy is low.
// Result channel: result is valid for the single cycle in which done is high;
// the receiver cannot stall, and the next item may be taken in that cycle.
// Body state sits in one synchronous body memory (one entry per body) that the
// sequencer reads, updates in working registers and writes back.
// Add writes a static body at once and runs one divide for a moving one.
// Step: one pass over the bodies (static, moving or floor bounce), then one
// per pair: a pair that is apart is skipped, else a square root and up to
// four divides run in sequence, plus the shared 34x34 multiplier passes.
// One item is in work at a time.
// Config: APB, register 0 floor_height at 0x0, register 1 floor_enable at 0x4.
// Reset empties the table and clears both registers; memory contents stay
// undefined and are never read before written.
`default_nettype none
module sphere_body_physics_step import sbps_pkg::*; #(
	parameter int MaxBodies = MAX_BODIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  cmd_t        cmd,
	output logic        busy,
	output logic        done,
	output res_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = $clog2(MaxBodies);
	localparam int CW = $clog2(MaxBodies + 1);

	typedef enum logic [22:0] {
		S_IDLE    = 23'h000001,
		S_ADD_DIV = 23'h000002,
		S_RD_WAIT = 23'h000004,
		S_RD_OUT  = 23'h000008,
		S_I_WAIT  = 23'h000010,
		S_I_LOAD  = 23'h000020,
		S_I_CALC  = 23'h000040,
		S_I_WR    = 23'h000080,
		S_P_WAITA = 23'h000100,
		S_P_LOADA = 23'h000200,
		S_P_LOADB = 23'h000400,
		S_P_CHK   = 23'h000800,
		S_P_SQ    = 23'h001000,
		S_P_SQRT  = 23'h002000,
		S_P_NDIV  = 23'h004000,
		S_P_POS   = 23'h008000,
		S_P_DOT   = 23'h010000,
		S_P_JM    = 23'h020000,
		S_P_JDIV  = 23'h040000,
		S_P_VEL   = 23'h080000,
		S_P_WRA   = 23'h100000,
		S_P_WRB   = 23'h200000,
		S_P_NEXT  = 23'h400000
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      ia_q;
	logic [CW-1:0]      ib_q;
	logic [IW-1:0]      addr_q;
	logic [1:0]         k_q;
	logic [2:0]         ph_q;
	logic [11:0]        dt_q;
	cmd_t               cmd_q;
	body_t              a_q;
	body_t              b_q;
	body_t              rd_q;
	logic [65:0]        sum_q;
	logic [31:0]        dist_q;
	logic signed [17:0] n_q [3];
	logic signed [69:0] dot_q;
	logic signed [31:0] vn_q;
	logic signed [31:0] jimp_q;
	logic signed [31:0] imp_q;
	logic signed [67:0] p_q;
	logic signed [31:0] floor_q;
	logic               fen_q;
	res_t               res_q;
	logic               done_q;

	body_t              body_mem [MaxBodies];
	logic               mem_we;
	logic [IW-1:0]      mem_wa;
	body_t              mem_wd;

	logic               div_start;
	logic [DVD_W-1:0]   div_dvd;
	logic [DSR_W-1:0]   div_dsr;
	logic               div_done;
	logic [DVD_W-1:0]   div_quo;
	logic [31:0]        quo_sat;
	logic               sq_start;
	logic [63:0]        sq_in;
	logic               sq_done;
	logic [31:0]        sq_root;

	logic signed [33:0] ma;
	logic signed [33:0] mb;
	logic signed [31:0] mq;
	logic signed [32:0] d [3];
	logic [32:0]        dabs [3];
	logic signed [32:0] rel [3];
	logic [31:0]        min_d;
	logic               far;
	logic [30:0]        ov;
	logic [32:0]        denom;
	logic [65:0]        sq_total;
	logic signed [69:0] dot_tot;
	logic signed [31:0] vn;
	logic signed [17:0] n_new;
	logic signed [33:0] py_ext;
	logic signed [33:0] rad_ext;
	logic signed [33:0] fl_ext;
	logic [CW:0]        cnt_w;
	logic [CW:0]        ia_inc1;
	logic [CW:0]        ia_inc2;
	logic [CW:0]        ib_inc1;
	logic               new_stat;
	body_t              new_body;

	sbps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	sbps_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_in),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			body_mem[mem_wa] <= mem_wd;
		end
		rd_q <= body_mem[addr_q];
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d[k]    = 33'($signed(b_q.pos[k])) - 33'($signed(a_q.pos[k]));
			dabs[k] = d[k][32] ? 33'(-d[k]) : 33'(d[k]);
			rel[k]  = 33'($signed(b_q.vel[k])) - 33'($signed(a_q.vel[k]));
		end
	end

	assign min_d    = 32'(a_q.rad) + 32'(b_q.rad);
	assign far      = (dabs[0] >= {1'b0, min_d}) || (dabs[1] >= {1'b0, min_d}) ||
	                  (dabs[2] >= {1'b0, min_d});
	assign ov       = 31'((min_d - dist_q) >> 1);
	assign denom    = 33'(a_q.inv) + 33'(b_q.inv);
	assign mq       = sat32(72'(p_q >>> 16));
	assign sq_total = sum_q + p_q[65:0];
	assign dot_tot  = dot_q + 70'(p_q);
	assign vn       = sat32(72'(dot_tot >>> 16));
	assign quo_sat  = (div_quo > DVD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_quo[31:0];
	assign n_new    = d[k_q][32] ? -$signed(div_quo[17:0]) : $signed(div_quo[17:0]);
	assign py_ext   = 34'($signed(b_q.pos[1]));
	assign rad_ext  = $signed({3'b000, b_q.rad});
	assign fl_ext   = 34'(floor_q);
	assign cnt_w    = (CW+1)'(cnt_q);
	assign ia_inc1  = (CW+1)'(ia_q) + (CW+1)'(1);
	assign ia_inc2  = (CW+1)'(ia_q) + (CW+1)'(2);
	assign ib_inc1  = (CW+1)'(ib_q) + (CW+1)'(1);

	assign new_stat = cmd_q.body_mass <= 32'sd0;
	always_comb begin
		new_body      = '0;
		new_body.pos  = {cmd_q.pos_z, cmd_q.pos_y, cmd_q.pos_x};
		new_body.rad  = cmd_q.body_radius;
		new_body.stat = new_stat;
		new_body.inv  = new_stat ? 32'd0 : quo_sat;
	end

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_I_CALC: begin
				case (ph_q)
					3'd0: begin
						ma = 34'(GRAV_Q);
						mb = 34'(dt_q);
					end
					3'd1, 3'd2, 3'd3: begin
						ma = 34'($signed(b_q.vel[ph_q[1:0] - 2'd1]));
						mb = 34'(dt_q);
					end
					3'd4: begin
						ma = 34'($signed(b_q.vel[1]));
						mb = 34'(REST_Q);
					end
					3'd5: begin
						ma = 34'($signed(b_q.vel[0]));
						mb = 34'(FRIC_Q);
					end
					3'd6: begin
						ma = 34'($signed(b_q.vel[2]));
						mb = 34'(FRIC_Q);
					end
					default: begin
						ma = '0;
						mb = '0;
					end
				endcase
			end
			S_P_SQ: begin
				if (ph_q < 3'd3) begin
					ma = 34'(dabs[ph_q[1:0]]);
					mb = 34'(dabs[ph_q[1:0]]);
				end
			end
			S_P_POS: begin
				if (ph_q < 3'd3) begin
					ma = 34'(n_q[ph_q[1:0]]);
					mb = 34'(ov);
				end
			end
			S_P_DOT: begin
				if (ph_q < 3'd3) begin
					ma = 34'(rel[ph_q[1:0]]);
					mb = 34'(n_q[ph_q[1:0]]);
				end
			end
			S_P_JM: begin
				ma = -34'(vn_q);
				mb = 34'(ONE_PLUS_REST_Q);
			end
			S_P_VEL: begin
				case (ph_q)
					3'd0: begin
						ma = 34'(n_q[k_q]);
						mb = 34'(jimp_q);
					end
					3'd2: begin
						ma = 34'(imp_q);
						mb = 34'($signed(a_q.inv));
					end
					3'd3: begin
						ma = 34'(imp_q);
						mb = 34'($signed(b_q.inv));
					end
					default: begin
						ma = '0;
						mb = '0;
					end
				endcase
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// divider and square root launch
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dsr   = '0;
		sq_start  = 1'b0;
		sq_in     = sq_total[63:0];
		case (state_q)
			S_IDLE: begin
				if (start && cmd.op == OP_ADD && cmd.body_mass > 32'sd0 &&
				    cnt_q < CW'(MaxBodies)) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'(33'h1_0000_0000);
					div_dsr   = DSR_W'(cmd.body_mass);
				end
			end
			S_P_SQ: begin
				sq_start = (ph_q == 3'd3) && (sq_total[65:64] == 2'b00);
			end
			S_P_SQRT: begin
				if (sq_done && sq_root != 32'd0 && sq_root < min_d) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'({dabs[0], 16'h0000});
					div_dsr   = DSR_W'(sq_root);
				end
			end
			S_P_NDIV: begin
				if (div_done && k_q != 2'd2) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'({dabs[k_q + 2'd1], 16'h0000});
					div_dsr   = DSR_W'(dist_q);
				end
			end
			S_P_JM: begin
				if (ph_q == 3'd1) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'({mq, 16'h0000});
					div_dsr   = denom;
				end
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = IW'(ia_q);
		mem_wd = b_q;
		case (state_q)
			S_ADD_DIV: begin
				mem_we = new_stat || div_done;
				mem_wa = cnt_q[IW-1:0];
				mem_wd = new_body;
			end
			S_I_WR: begin
				mem_we = 1'b1;
			end
			S_P_WRA: begin
				mem_we = 1'b1;
				mem_wd = a_q;
			end
			S_P_WRB: begin
				mem_we = 1'b1;
				mem_wa = IW'(ib_q);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ia_q    <= '0;
			ib_q    <= '0;
			addr_q  <= '0;
			k_q     <= '0;
			ph_q    <= '0;
			dt_q    <= '0;
			cmd_q   <= '0;
			a_q     <= '0;
			b_q     <= '0;
			sum_q   <= '0;
			dist_q  <= '0;
			n_q     <= '{default: '0};
			dot_q   <= '0;
			vn_q    <= '0;
			jimp_q  <= '0;
			imp_q   <= '0;
			p_q     <= '0;
			floor_q <= '0;
			fen_q   <= 1'b0;
			res_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			p_q    <= ma * mb;

			if (psel && penable && pwrite) begin
				if (paddr[2]) begin
					fen_q <= pwdata[0];
				end else begin
					floor_q <= pwdata;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						case (cmd.op)
							OP_ADD: begin
								if (cnt_q >= CW'(MaxBodies)) begin
									res_q       <= '0;
									res_q.error <= 1'b1;
									done_q      <= 1'b1;
								end else begin
									state_q <= S_ADD_DIV;
								end
							end
							OP_STEP: begin
								dt_q   <= (cmd.time_step > 16'(DT_LIMIT)) ? 12'(DT_LIMIT) :
								          cmd.time_step[11:0];
								ia_q   <= '0;
								addr_q <= '0;
								if (cnt_q == '0) begin
									res_q  <= '0;
									done_q <= 1'b1;
								end else begin
									state_q <= S_I_WAIT;
								end
							end
							OP_READ: begin
								if (32'(cmd.body_index) >= 32'(cnt_q)) begin
									res_q       <= '0;
									res_q.error <= 1'b1;
									done_q      <= 1'b1;
								end else begin
									addr_q  <= IW'(cmd.body_index);
									state_q <= S_RD_WAIT;
								end
							end
							OP_CLEAR: begin
								cnt_q  <= '0;
								res_q  <= '0;
								done_q <= 1'b1;
							end
							default: begin
								res_q  <= '0;
								done_q <= 1'b1;
							end
						endcase
					end
				end

				S_ADD_DIV: begin
					if (new_stat || div_done) begin
						cnt_q            <= cnt_q + CW'(1);
						res_q            <= '0;
						res_q.out_handle <= 4'(cnt_q);
						done_q           <= 1'b1;
						state_q          <= S_IDLE;
					end
				end

				S_RD_WAIT: begin
					state_q <= S_RD_OUT;
				end

				S_RD_OUT: begin
					res_q       <= '0;
					res_q.out_x <= rd_q.pos[0];
					res_q.out_y <= rd_q.pos[1];
					res_q.out_z <= rd_q.pos[2];
					done_q      <= 1'b1;
					state_q     <= S_IDLE;
				end

				S_I_WAIT: begin
					state_q <= S_I_LOAD;
				end

				S_I_LOAD: begin
					b_q     <= rd_q;
					ph_q    <= '0;
					state_q <= rd_q.stat ? S_I_WR : S_I_CALC;
				end

				S_I_CALC: begin
					ph_q <= ph_q + 3'd1;
					case (ph_q)
						3'd0: begin
						end
						3'd1: begin
							b_q.vel[1] <= sat32(72'($signed(b_q.vel[1])) + 72'(mq));
						end
						3'd2, 3'd3: begin
							b_q.pos[ph_q[1:0] - 2'd2] <=
								sat32(72'($signed(b_q.pos[ph_q[1:0] - 2'd2])) + 72'(mq));
						end
						3'd4: begin
							b_q.pos[2] <= sat32(72'($signed(b_q.pos[2])) + 72'(mq));
							if (fen_q && (py_ext - rad_ext < fl_ext)) begin
								b_q.pos[1] <= sat32(72'(fl_ext + rad_ext));
							end else begin
								state_q <= S_I_WR;
							end
						end
						3'd5: begin
							b_q.vel[1] <= sat32(-72'(mq));
						end
						3'd6: begin
							b_q.vel[0] <= mq;
						end
						default: begin
							b_q.vel[2] <= mq;
							state_q    <= S_I_WR;
						end
					endcase
				end

				S_I_WR: begin
					if (ia_inc1 == cnt_w) begin
						if (cnt_q < CW'(2)) begin
							res_q   <= '0;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							ia_q    <= '0;
							ib_q    <= CW'(1);
							addr_q  <= '0;
							state_q <= S_P_WAITA;
						end
					end else begin
						ia_q    <= CW'(ia_inc1);
						addr_q  <= IW'(ia_inc1);
						state_q <= S_I_WAIT;
					end
				end

				S_P_WAITA: begin
					addr_q  <= IW'(ib_q);
					state_q <= S_P_LOADA;
				end

				S_P_LOADA: begin
					a_q     <= rd_q;
					state_q <= S_P_LOADB;
				end

				S_P_LOADB: begin
					b_q     <= rd_q;
					state_q <= S_P_CHK;
				end

				S_P_CHK: begin
					ph_q    <= '0;
					sum_q   <= '0;
					state_q <= far ? S_P_NEXT : S_P_SQ;
				end

				S_P_SQ: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd1 || ph_q == 3'd2) begin
						sum_q <= sq_total;
					end else if (ph_q == 3'd3) begin
						state_q <= (sq_total[65:64] == 2'b00) ? S_P_SQRT : S_P_NEXT;
					end
				end

				S_P_SQRT: begin
					if (sq_done) begin
						dist_q <= sq_root;
						k_q    <= '0;
						if (sq_root != 32'd0 && sq_root < min_d) begin
							state_q <= S_P_NDIV;
						end else begin
							state_q <= S_P_NEXT;
						end
					end
				end

				S_P_NDIV: begin
					if (div_done) begin
						n_q[k_q] <= n_new;
						k_q      <= k_q + 2'd1;
						if (k_q == 2'd2) begin
							ph_q    <= '0;
							state_q <= S_P_POS;
						end
					end
				end

				S_P_POS: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q != 3'd0) begin
						if (!a_q.stat) begin
							a_q.pos[ph_q[1:0] - 2'd1] <=
								sat32(72'($signed(a_q.pos[ph_q[1:0] - 2'd1])) - 72'(mq));
						end
						if (!b_q.stat) begin
							b_q.pos[ph_q[1:0] - 2'd1] <=
								sat32(72'($signed(b_q.pos[ph_q[1:0] - 2'd1])) + 72'(mq));
						end
						if (ph_q == 3'd3) begin
							ph_q    <= '0;
							state_q <= S_P_DOT;
						end
					end
				end

				S_P_DOT: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd1) begin
						dot_q <= 70'(p_q);
					end else if (ph_q == 3'd2) begin
						dot_q <= dot_tot;
					end else if (ph_q == 3'd3) begin
						vn_q <= vn;
						ph_q <= '0;
						if (vn >= 32'sd0 || denom == '0) begin
							state_q <= S_P_WRA;
						end else begin
							state_q <= S_P_JM;
						end
					end
				end

				S_P_JM: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd1) begin
						state_q <= S_P_JDIV;
					end
				end

				S_P_JDIV: begin
					if (div_done) begin
						jimp_q  <= quo_sat;
						k_q     <= '0;
						ph_q    <= '0;
						state_q <= S_P_VEL;
					end
				end

				S_P_VEL: begin
					ph_q <= ph_q + 3'd1;
					case (ph_q)
						3'd1: begin
							imp_q <= mq;
						end
						3'd3: begin
							if (!a_q.stat) begin
								a_q.vel[k_q] <= sat32(72'($signed(a_q.vel[k_q])) - 72'(mq));
							end
						end
						3'd4: begin
							if (!b_q.stat) begin
								b_q.vel[k_q] <= sat32(72'($signed(b_q.vel[k_q])) + 72'(mq));
							end
							ph_q <= '0;
							k_q  <= k_q + 2'd1;
							if (k_q == 2'd2) begin
								state_q <= S_P_WRA;
							end
						end
						default: begin
						end
					endcase
				end

				S_P_WRA: begin
					state_q <= S_P_WRB;
				end

				S_P_WRB: begin
					state_q <= S_P_NEXT;
				end

				S_P_NEXT: begin
					if (ib_inc1 < cnt_w) begin
						ib_q    <= CW'(ib_inc1);
						addr_q  <= IW'(ia_q);
						state_q <= S_P_WAITA;
					end else if (ia_inc2 < cnt_w) begin
						ia_q    <= CW'(ia_inc1);
						ib_q    <= CW'(ia_inc2);
						addr_q  <= IW'(ia_inc1);
						state_q <= S_P_WAITA;
					end else begin
						res_q   <= '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;
	assign prdata = paddr[2] ? {31'd0, fen_q} : floor_q;
	assign pready = 1'b1;

endmodule
`default_nettype wire
